// ----- design/c3ms_pkg.sv -----
// Shared types and constants for the 3x3 multichannel convolution stream unit.
package c3ms_pkg;

  localparam int DATA_W   = 64;
  localparam int HALF_W   = 32;
  localparam int TAPS     = 9;
  localparam int ALL_TAPS = 27;
  localparam int POS_W    = 9;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [1:0] CFG_OUT_COLS      = 2'd0;
  localparam logic [1:0] CFG_OUT_ROWS      = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         weight_index;
    logic signed [63:0] weight_value;
    logic signed [63:0] pixel_ch0;
    logic signed [63:0] pixel_ch1;
    logic signed [63:0] pixel_ch2;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               frame_last;
  } out_item_t;

  // Per-cycle control that the top level hands to every lane.
  typedef struct packed {
    logic       adv;
    logic       rd_en;
    logic       wr_en;
    logic       shift_en;
    logic       wt_en;
    logic [1:0] wt_lane;
    logic [3:0] wt_tap;
  } lane_ctrl_t;

endpackage

// ----- design/c3ms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module c3ms_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 130,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/c3ms_lane.sv -----
// One channel lane: two line buffers, a 3x3 window, nine weights and a MAC tree.
module c3ms_lane #(
  parameter int MAX_COLS = 128,
  parameter logic [1:0] LANE_ID = 2'd0,
  localparam int AW = $clog2(MAX_COLS + 2)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  c3ms_pkg::lane_ctrl_t   ctrl,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          wr_addr,
  input  logic [63:0]            sample,
  input  logic [63:0]            wt_value,
  output logic [63:0]            lane_sum
);
  import c3ms_pkg::*;

  logic [2*DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0]   col_c [0:2];

  logic [DATA_W-1:0] win_r [0:TAPS-1];
  logic [DATA_W-1:0] wt_r  [0:TAPS-1];
  logic [DATA_W-1:0] ll_r  [0:TAPS-1];
  logic [HALF_W-1:0] lh_r  [0:TAPS-1];
  logic [HALF_W-1:0] hl_r  [0:TAPS-1];
  logic [DATA_W-1:0] prod_r [0:TAPS-1];
  logic [DATA_W-1:0] grp_r [0:2];
  logic [DATA_W-1:0] sum_r;

  logic [DATA_W-1:0] ll_c [0:TAPS-1];
  logic [HALF_W-1:0] lh_c [0:TAPS-1];
  logic [HALF_W-1:0] hl_c [0:TAPS-1];

  // Each RAM word holds the two older rows of one column: low half is the oldest.
  c3ms_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_COLS + 2)) u_line (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (wr_addr),
    .wdata ({sample, ram_rdata[2*DATA_W-1:DATA_W]}),
    .re    (ctrl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign col_c[0] = ram_rdata[DATA_W-1:0];
  assign col_c[1] = ram_rdata[2*DATA_W-1:DATA_W];
  assign col_c[2] = sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAPS; t++) begin
        win_r[t] <= '0;
      end
    end else if (ctrl.shift_en) begin
      for (int kr = 0; kr < 3; kr++) begin
        win_r[kr*3]     <= win_r[kr*3 + 1];
        win_r[kr*3 + 1] <= win_r[kr*3 + 2];
        win_r[kr*3 + 2] <= col_c[kr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wt_en && ctrl.wt_lane == LANE_ID) begin
      wt_r[ctrl.wt_tap] <= wt_value;
    end
  end

  // 64x64 product modulo 2^64 from three 32x32 partial products.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      ll_c[t] = win_r[t][HALF_W-1:0] * wt_r[t][HALF_W-1:0];
      lh_c[t] = win_r[t][HALF_W-1:0] * wt_r[t][DATA_W-1:HALF_W];
      hl_c[t] = win_r[t][DATA_W-1:HALF_W] * wt_r[t][HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int t = 0; t < TAPS; t++) begin
        ll_r[t]   <= ll_c[t];
        lh_r[t]   <= lh_c[t];
        hl_r[t]   <= hl_c[t];
        prod_r[t] <= ll_r[t] + {lh_r[t] + hl_r[t], {HALF_W{1'b0}}};
      end
      for (int g = 0; g < 3; g++) begin
        grp_r[g] <= prod_r[g*3] + prod_r[g*3 + 1] + prod_r[g*3 + 2];
      end
      sum_r <= grp_r[0] + grp_r[1] + grp_r[2];
    end
  end

  assign lane_sum = sum_r;

endmodule

// ----- design/c3ms_merge.sv -----
// Merge stage: adds the active lanes and holds the output item register.
module c3ms_merge #(
  parameter int NL = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [1:0]            chans,
  input  logic                  res_in,
  input  logic                  last_in,
  input  logic [63:0]           lane_sum [0:NL-1],
  output logic                  out_valid,
  output c3ms_pkg::out_item_t   out_item
);
  import c3ms_pkg::*;

  logic        valid_r;
  out_item_t   item_r;
  logic [63:0] acc_c;

  always_comb begin
    acc_c = '0;
    for (int l = 0; l < NL; l++) begin
      if (2'(l) < chans) begin
        acc_c = acc_c + lane_sum[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r.result_value <= acc_c;
      item_r.frame_last   <= last_in;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- design/conv3x3_multichannel_stream_unit.sv -----
// Top level of the streaming 3x3 multichannel convolution unit.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | c3ms_pkg::in_item_t
//   out     | output    | out_valid/out_stall| c3ms_pkg::out_item_t
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One item is accepted per cycle while in_stall is low; out_valid rises once its pixel has passed
// the line buffer read, the window, the split 64-bit multipliers and
// the adder tree of each lane, then the lane merge. Reset clears the window,
// positions and control; weights and line buffers hold nothing until written.
// While a result waits under out_stall the whole pipeline holds and in_stall is high.
module conv3x3_multichannel_stream_unit #(
  parameter int MAX_COLS     = 128,
  parameter int MAX_CHANNELS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  c3ms_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c3ms_pkg::out_item_t  out_item,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import c3ms_pkg::*;

  localparam int AW = $clog2(MAX_COLS + 2);
  localparam int NPIPE = 5;

  logic [7:0] out_cols_r, out_rows_r;
  logic [1:0] chan_cnt_r;
  logic [POS_W-1:0] col_r, row_r;

  logic [POS_W-1:0] cols_c, rows_c, last_col_c, last_row_c, c_cur, r_cur;
  logic [1:0]       chans_c;
  logic             adv, accept, px_accept, res_c, last_c;

  logic             a_vld_r, a_op_r, a_res_r, a_last_r;
  logic [4:0]       a_widx_r;
  logic [63:0]      a_wval_r;
  logic [63:0]      a_pix_r [0:2];
  logic [AW-1:0]    a_addr_r;

  logic             res_r  [0:NPIPE-1];
  logic             last_r [0:NPIPE-1];

  lane_ctrl_t       ctrl;
  logic [63:0]      lane_sum [0:MAX_CHANNELS-1];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign px_accept = accept && in_item.opcode == OP_PIXEL;

  // Size and channel registers are clamped to their legal ranges here; the frame position is decoded.
  always_comb begin
    if (out_cols_r == 8'd0) cols_c = POS_W'(1);
    else if (int'(out_cols_r) > MAX_COLS) cols_c = POS_W'(MAX_COLS);
    else cols_c = POS_W'(out_cols_r);
    if (out_rows_r == 8'd0) rows_c = POS_W'(1);
    else if (int'(out_rows_r) > MAX_COLS) rows_c = POS_W'(MAX_COLS);
    else rows_c = POS_W'(out_rows_r);
    if (chan_cnt_r == 2'd0) chans_c = 2'd1;
    else if (int'(chan_cnt_r) > MAX_CHANNELS) chans_c = 2'(MAX_CHANNELS);
    else chans_c = chan_cnt_r;
    last_col_c = cols_c + POS_W'(1);
    last_row_c = rows_c + POS_W'(1);
    c_cur = (col_r > last_col_c) ? '0 : col_r;
    r_cur = (row_r > last_row_c) ? '0 : row_r;
    res_c  = r_cur >= POS_W'(2) && c_cur >= POS_W'(2);
    last_c = r_cur == last_row_c && c_cur == last_col_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cols_r <= 8'd128;
      out_rows_r <= 8'd128;
      chan_cnt_r <= 2'd3;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_wr_en) begin
      priority case (cfg_index)
        CFG_OUT_COLS: begin
          out_cols_r <= cfg_wdata;
          col_r <= '0;
          row_r <= '0;
        end
        CFG_OUT_ROWS: begin
          out_rows_r <= cfg_wdata;
          col_r <= '0;
          row_r <= '0;
        end
        CFG_CHANNEL_COUNT: begin
          chan_cnt_r <= cfg_wdata[1:0];
          col_r <= '0;
          row_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (px_accept) begin
      if (c_cur == last_col_c) begin
        col_r <= '0;
        row_r <= (r_cur == last_row_c) ? '0 : r_cur + POS_W'(1);
      end else begin
        col_r <= c_cur + POS_W'(1);
        row_r <= r_cur;
      end
    end
  end

  // Stage A: accepted item, line buffer read data arrives alongside it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r     <= in_item.opcode;
      a_widx_r   <= in_item.weight_index;
      a_wval_r   <= in_item.weight_value;
      a_pix_r[0] <= in_item.pixel_ch0;
      a_pix_r[1] <= in_item.pixel_ch1;
      a_pix_r[2] <= in_item.pixel_ch2;
      a_addr_r   <= AW'(c_cur);
      a_res_r    <= res_c;
      a_last_r   <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NPIPE; s++) begin
        res_r[s] <= 1'b0;
      end
    end else if (adv) begin
      res_r[0] <= a_vld_r && a_op_r == OP_PIXEL && a_res_r;
      for (int s = 1; s < NPIPE; s++) begin
        res_r[s] <= res_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[0] <= a_last_r;
      for (int s = 1; s < NPIPE; s++) begin
        last_r[s] <= last_r[s-1];
      end
    end
  end

  // Weight index to lane and tap: three ranges of nine.
  always_comb begin
    ctrl.adv      = adv;
    ctrl.rd_en    = px_accept;
    ctrl.wr_en    = adv && a_vld_r && a_op_r == OP_PIXEL;
    ctrl.shift_en = adv && a_vld_r && a_op_r == OP_PIXEL;
    ctrl.wt_en    = adv && a_vld_r && a_op_r == OP_WEIGHT && a_widx_r < 5'(ALL_TAPS);
    if (a_widx_r < 5'd9) begin
      ctrl.wt_lane = 2'd0;
      ctrl.wt_tap  = a_widx_r[3:0];
    end else if (a_widx_r < 5'd18) begin
      ctrl.wt_lane = 2'd1;
      ctrl.wt_tap  = 4'(a_widx_r - 5'd9);
    end else begin
      ctrl.wt_lane = 2'd2;
      ctrl.wt_tap  = 4'(a_widx_r - 5'd18);
    end
  end

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    c3ms_lane #(.MAX_COLS(MAX_COLS), .LANE_ID(2'(l))) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .rd_addr  (AW'(c_cur)),
      .wr_addr  (a_addr_r),
      .sample   (a_pix_r[l]),
      .wt_value (a_wval_r),
      .lane_sum (lane_sum[l])
    );
  end

  c3ms_merge #(.NL(MAX_CHANNELS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .chans     (chans_c),
    .res_in    (res_r[NPIPE-1]),
    .last_in   (last_r[NPIPE-1]),
    .lane_sum  (lane_sum),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- dv/tb_conv3x3_multichannel_stream_unit.sv -----
// Self-checking testbench for the streaming 3x3 multichannel convolution unit.
module tb_conv3x3_multichannel_stream_unit;
  import c3ms_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [7:0]          cfg_wdata;

  conv3x3_multichannel_stream_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state.
  logic [63:0] line_mem [0:2][0:1][0:129];
  logic [63:0] win      [0:26];
  logic [63:0] weights  [0:26];
  int unsigned col_pos, row_pos;
  logic [7:0]  cols_reg, rows_reg;
  logic [1:0]  chans_reg;

  out_item_t   expected_results [$];
  int          error_count;
  int          idle_cycles;
  int          hold_off;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned sat(input int unsigned v, input int unsigned lo,
                                      input int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Advances the predictor by one accepted item.
  task automatic predict_conv(input in_item_t it);
    int unsigned cols, rows, chans, lc, lr, c, r;
    logic [63:0] col_vals [0:2];
    logic [63:0] samp [0:2];
    logic [63:0] acc;
    out_item_t   res;
    if (it.opcode == OP_WEIGHT) begin
      if (it.weight_index < ALL_TAPS) weights[it.weight_index] = it.weight_value;
      return;
    end
    cols = sat(cols_reg, 1, 128);
    rows = sat(rows_reg, 1, 128);
    chans = sat(chans_reg, 1, 3);
    lc = cols + 1;
    lr = rows + 1;
    c = col_pos;
    r = row_pos;
    if (c > lc || c >= 130) c = 0;
    if (r > lr) r = 0;
    samp[0] = it.pixel_ch0;
    samp[1] = it.pixel_ch1;
    samp[2] = it.pixel_ch2;
    for (int ch = 0; ch < 3; ch++) begin
      col_vals[0] = line_mem[ch][0][c];
      col_vals[1] = line_mem[ch][1][c];
      col_vals[2] = samp[ch];
      line_mem[ch][0][c] = line_mem[ch][1][c];
      line_mem[ch][1][c] = samp[ch];
      for (int kr = 0; kr < 3; kr++) begin
        win[ch*9 + kr*3]     = win[ch*9 + kr*3 + 1];
        win[ch*9 + kr*3 + 1] = win[ch*9 + kr*3 + 2];
        win[ch*9 + kr*3 + 2] = col_vals[kr];
      end
    end
    if (r >= 2 && c >= 2) begin
      acc = '0;
      for (int t = 0; t < chans * 9; t++) acc += win[t] * weights[t];
      res.result_value = acc;
      res.frame_last = (r == lr && c == lc);
      expected_results.push_back(res);
    end
    if (c == lc) begin
      c = 0;
      r = (r == lr) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return '0;
      4: return 64'($signed($urandom_range(0, 20)) - 10);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(5, 30);
    return $urandom_range(1, 3);
  endfunction

  // Offers one item and waits until it is taken; valid stays up for the next item.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = short_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_conv(it);
  endtask

  task automatic send_weight(input int idx, input logic [63:0] val);
    in_item_t it;
    it = '0;
    it.opcode = OP_WEIGHT;
    it.weight_index = 5'(idx);
    it.weight_value = val;
    it.pixel_ch0 = rand64();
    send_item(it);
  endtask

  task automatic send_pixel(input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] d);
    in_item_t it;
    it.opcode = OP_PIXEL;
    it.weight_index = 5'($urandom);
    it.weight_value = {$urandom, $urandom};
    it.pixel_ch0 = a;
    it.pixel_ch1 = b;
    it.pixel_ch2 = d;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a configuration register while the block is idle; a defined index restarts the frame.
  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_OUT_COLS) cols_reg = val;
    else if (idx == CFG_OUT_ROWS) rows_reg = val;
    else if (idx == CFG_CHANNEL_COUNT) chans_reg = val[1:0];
    if (idx <= CFG_CHANNEL_COUNT) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic load_all_weights(input bit extremes);
    for (int i = 0; i < ALL_TAPS; i++)
      send_weight(i, extremes ? ((i % 2) ? 64'h7FFF_FFFF_FFFF_FFFF
                                          : 64'h8000_0000_0000_0000) : rand64());
  endtask

  task automatic send_frame(input int unsigned cols, input int unsigned rows);
    for (int i = 0; i < (cols + 2) * (rows + 2); i++)
      send_pixel(rand64(), rand64(), rand64());
  endtask

  task automatic set_size(input logic [7:0] c, input logic [7:0] r,
                          input logic [1:0] n);
    wait_drained();
    write_cfg(CFG_OUT_COLS, c);
    write_cfg(CFG_OUT_ROWS, r);
    write_cfg(CFG_CHANNEL_COUNT, n);
  endtask

  // Smallest frame, extreme weights, ignored bad index and an unused register index.
  task automatic test_directed();
    set_size(8'd1, 8'd1, 2'd3);
    load_all_weights(1'b1);
    send_weight(31, 64'h1234);
    send_weight(27, '1);
    wait_drained();
    write_cfg(2'd3, 8'hFF);
    send_pixel(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    for (int i = 0; i < 8; i++) send_pixel(rand64(), rand64(), rand64());
  endtask

  // Out-of-range sizes saturate; zero acts as one.
  task automatic test_saturation();
    set_size(8'd0, 8'd0, 2'd0);
    load_all_weights(1'b0);
    send_frame(1, 1);
    set_size(8'd255, 8'd0, 2'd1);
    send_frame(128, 1);
    set_size(8'd128, 8'd1, 2'd2);
    send_frame(128, 1);
  endtask

  // Back-to-back frames of random small sizes with weight updates between them.
  task automatic test_random_frames();
    int unsigned c, r;
    int sent;
    sent = 0;
    while (sent < 100) begin
      c = $urandom_range(1, 6);
      r = $urandom_range(1, 5);
      set_size(8'(c), 8'(r), 2'($urandom_range(1, 3)));
      repeat ($urandom_range(0, 3))
        send_weight($urandom_range(0, 31), rand64());
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        send_frame(c, r);
        sent += (c + 2) * (r + 2);
        if ($urandom_range(0, 3) == 0) begin
          send_weight($urandom_range(0, 26), rand64());
          sent++;
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while pixels keep coming.
  task automatic test_back_pressure();
    set_size(8'd4, 8'd4, 2'd3);
    hold_off = 200;
    send_frame(4, 4);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0) ||
                   ($urandom_range(0, 40) == 0 ? 1'b1 : 1'b0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_item.result_value !== exp_r.result_value)
          report_mismatch($sformatf("result_value got %h exp %h",
                                    out_item.result_value, exp_r.result_value));
        if (out_item.frame_last !== exp_r.frame_last)
          report_mismatch($sformatf("frame_last got %b exp %b",
                                    out_item.frame_last, exp_r.frame_last));
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    hold_off = 0;
    for (int i = 0; i < 27; i++) begin
      win[i] = '0;
      weights[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    cols_reg = 8'd128;
    rows_reg = 8'd128;
    chans_reg = 2'd3;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_back_pressure();
    test_random_frames();
    wait_drained();
    if (error_count == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
